// ===== hdl/wmn_pkg.sv =====
// Package for the case-insensitive glob matcher: store size, derived widths,
// item codes and the ASCII lowering function. No dependencies.
package wmn_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_N = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int STEPS = (POS_N > 1) ? $clog2(POS_N) : 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_STRING = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Only 'A'..'Z' are changed.
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// ===== hdl/wildcard_match_nocase.sv =====
// Top level of the case-insensitive glob matcher: pattern store, active
// position set and result register. Depends on wmn_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   item     | item_valid / item_ready    | opcode, char_byte
//   result   | result_valid / result_ready| matched, pattern_overflow
//
// The star closure is a six-step prefix network and the position update one
// compare per entry, all between the position register and its next value.
// A result appears in the cycle after its end-of-string word is accepted.
// Reset (rst, synchronous) empties the pattern, clears the overflow flag
// and leaves only position zero active. item_ready drops only when a
// result is held and result_ready is low.
module wildcard_match_nocase
  import wmn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] char_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       matched,
  output logic       pattern_overflow
);

  // Pattern store holds lowered bytes plus per-entry star and any flags.
  logic [7:0]             pattern_store [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_flags;
  logic [PATTERN_MAX-1:0] any_flags;
  logic [LEN_W-1:0]       pattern_length;
  logic                   overflow_flag;
  logic [POS_N-1:0]       active_positions;
  logic [POS_N-1:0]       active_next;
  logic [POS_N-1:0]       closed;
  logic [POS_N-1:0]       gen;
  logic [POS_N-1:0]       prop;
  logic [POS_N-1:0]       gen_step;
  logic [POS_N-1:0]       prop_step;
  logic [PATTERN_MAX-1:0] entry_used;
  logic [7:0]             lc;
  logic                   accept;
  logic [POS_N-1:0]       restart;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign lc         = lower_ascii(char_byte);
  assign restart    = POS_N'(1);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      entry_used[i] = (LEN_W'(i) < pattern_length);
    end
  end

  // Star closure as a parallel prefix: a position is reached if some active
  // position below it is joined to it by a run of stored stars.
  always_comb begin
    int d;
    gen     = active_positions;
    prop    = '0;
    for (int i = 1; i < POS_N; i++) begin
      prop[i] = star_flags[i-1] && entry_used[i-1];
    end
    gen_step  = gen;
    prop_step = prop;
    for (int s = 0; s < STEPS; s++) begin
      d         = 1 << s;
      gen_step  = gen;
      prop_step = prop;
      for (int i = 0; i < POS_N; i++) begin
        if (i >= d) begin
          gen_step[i]  = gen[i] | (prop[i] & gen[i-d]);
          prop_step[i] = prop[i] & prop[i-d];
        end
      end
      gen  = gen_step;
      prop = prop_step;
    end
    closed = gen;
  end

  always_comb begin
    active_next = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (closed[i] && entry_used[i]) begin
        if (star_flags[i]) begin
          active_next[i] = 1'b1;
        end else if (any_flags[i] || pattern_store[i] == lc) begin
          active_next[i+1] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_APPEND && char_byte != ZERO_BYTE &&
        pattern_length < LEN_W'(PATTERN_MAX)) begin
      pattern_store[pattern_length[IDX_W-1:0]] <= lower_ascii(char_byte);
      star_flags[pattern_length[IDX_W-1:0]]    <= (char_byte == STAR_BYTE);
      any_flags[pattern_length[IDX_W-1:0]]     <= (char_byte == ANY_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      overflow_flag    <= 1'b0;
      active_positions <= restart;
      result_valid     <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        case (opcode)
          OP_CLEAR: begin
            pattern_length   <= '0;
            overflow_flag    <= 1'b0;
            active_positions <= restart;
          end
          OP_APPEND: begin
            if (char_byte != ZERO_BYTE) begin
              if (pattern_length < LEN_W'(PATTERN_MAX)) begin
                pattern_length <= pattern_length + LEN_W'(1);
              end else begin
                overflow_flag <= 1'b1;
              end
              active_positions <= restart;
            end
          end
          OP_STRING: begin
            if (char_byte != ZERO_BYTE) begin
              active_positions <= active_next;
            end
          end
          default: begin
            result_valid     <= 1'b1;
            active_positions <= restart;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_END) begin
      matched          <= closed[pattern_length];
      pattern_overflow <= overflow_flag;
    end
  end

endmodule

// ===== hdl/wmn_checker.sv =====
// Port-level checker for the glob matcher, with its bind to the top level.
// Depends on wmn_pkg.
module wmn_checker
  import wmn_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic [1:0] opcode,
  input logic       result_valid,
  input logic       result_ready,
  input logic       matched,
  input logic       pattern_overflow
);

  logic item_acc;
  assign item_acc = item_valid && item_ready;

  // A held result keeps its word.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(matched) && $stable(pattern_overflow))
    else $error("result word changed while stalled");

  // A held result blocks new words.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("item accepted while a result is stalled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_acc && opcode == OP_END |=> result_valid)
    else $error("end of string gave no result");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    item_acc && opcode != OP_END && !result_valid |=> !result_valid)
    else $error("result without end of string");

  // An empty pattern matches the empty string, with no overflow.
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (item_acc && opcode == OP_CLEAR) ##1 (item_acc && opcode == OP_END) |=>
      matched && !pattern_overflow)
    else $error("empty pattern did not match empty string");

endmodule

bind wildcard_match_nocase wmn_checker u_wmn_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item_valid),
  .item_ready       (item_ready),
  .opcode           (opcode),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .matched          (matched),
  .pattern_overflow (pattern_overflow)
);

// ===== test/match_monitor.sv =====
// Monitor for the case-insensitive glob matcher: watches both channels, keeps its
// own copy of the pattern and active position set, and checks each result word.
// Depends on wmn_pkg.
module match_monitor
  import wmn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] char_byte,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic       matched,
  input  logic       pattern_overflow,
  output int         mismatch_count,
  output int         results_owed
);

  typedef struct packed {
    logic hit;
    logic full;
  } verdict_t;

  localparam logic [POS_N-1:0] ONLY_START = POS_N'(1);

  logic [7:0]       pat_bytes [PATTERN_MAX];
  int               pat_len;
  logic [POS_N-1:0] live_pos;
  logic             dropped_bytes;
  verdict_t         verdicts_due [$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  // A star at an active position also makes the position after it active.
  // Walking upward lets a run of stars pass the flag all the way along.
  function automatic void spread_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i] && pat_bytes[i] == STAR_BYTE) begin
        live_pos[i+1] = 1'b1;
      end
    end
  endfunction

  function automatic void step_char(input logic [7:0] c);
    logic [POS_N-1:0] nxt;
    nxt = '0;
    spread_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_bytes[i] == STAR_BYTE) begin
          nxt[i] = 1'b1;
        end else if (pat_bytes[i] == ANY_BYTE || fold_case(pat_bytes[i]) == fold_case(c)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    live_pos = nxt;
  endfunction

  function automatic void absorb_word(input logic [1:0] op, input logic [7:0] c);
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        dropped_bytes = 1'b0;
        live_pos = ONLY_START;
      end
      OP_APPEND: begin
        if (c != ZERO_BYTE) begin
          if (pat_len < PATTERN_MAX) begin
            pat_bytes[pat_len] = c;
            pat_len++;
          end else begin
            dropped_bytes = 1'b1;
          end
          live_pos = ONLY_START;
        end
      end
      OP_STRING: begin
        if (c != ZERO_BYTE) begin
          step_char(c);
        end
      end
      default: begin
        spread_stars();
        verdicts_due.push_back({live_pos[pat_len], dropped_bytes});
        live_pos = ONLY_START;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      pat_len = 0;
      dropped_bytes = 1'b0;
      live_pos = ONLY_START;
      verdicts_due.delete();
    end else begin
      // Results are taken before the item at the same edge, since a result
      // always belongs to an earlier end-of-string word.
      if (result_valid && result_ready) begin
        if (verdicts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result word with nothing expected: matched=%0b overflow=%0b",
                     $time, matched, pattern_overflow);
          end
        end else begin
          want = verdicts_due.pop_front();
          if (matched !== want.hit || pattern_overflow !== want.full) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                       $time, want.hit, want.full, matched, pattern_overflow);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        absorb_word(opcode, char_byte);
      end
    end
    results_owed = verdicts_due.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the case-insensitive glob matcher: clock, reset, directed and
// random words, result backpressure and the verdict. Depends on wmn_pkg,
// wildcard_match_nocase and match_monitor.
module tb
  import wmn_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 720;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic [1:0] opcode = OP_CLEAR;
  logic [7:0] char_byte = ZERO_BYTE;
  logic       result_ready = 1'b0;
  logic       item_ready;
  logic       result_valid;
  logic       matched;
  logic       pattern_overflow;
  int         mismatch_count;
  int         results_owed;

  bit         calm = 1'b1;
  int         stall_left = 0;
  int         cycle_count = 0;
  int         words_sent = 0;
  logic [7:0] cur_pat [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wildcard_match_nocase u_top (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .opcode           (opcode),
    .char_byte        (char_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  match_monitor u_match_monitor (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .opcode           (opcode),
    .char_byte        (char_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow),
    .mismatch_count   (mismatch_count),
    .results_owed     (results_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL wildcard_match_nocase");
      $finish;
    end
  end

  // Result stalls: mostly short, now and then long, none started while calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  function automatic logic [7:0] pick_letter();
    return 8'h41 + 8'($urandom_range(0, 1)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) begin
      return STAR_BYTE;
    end else if (r < 6) begin
      return ANY_BYTE;
    end else if (r < 13) begin
      return pick_letter();
    end
    return 8'($urandom);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] c);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 2);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    char_byte <= c;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    // Keep a copy of the pattern so that strings can be built to match it.
    if (op == OP_CLEAR) begin
      cur_pat.delete();
    end else if (op == OP_APPEND && c != ZERO_BYTE && cur_pat.size() < PATTERN_MAX) begin
      cur_pat.push_back(c);
    end
    if (!((op == OP_APPEND || op == OP_STRING) && c == ZERO_BYTE)) begin
      words_sent++;
    end
  endtask

  initial begin
    logic [7:0] text [$];
    logic [7:0] p;
    int         plen;
    int         pick;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern: only the empty string matches, and zero bytes are ignored.
    send_word(OP_END, 8'hFF);
    send_word(OP_STRING, "a");
    send_word(OP_END, 8'h00);
    send_word(OP_STRING, ZERO_BYTE);
    send_word(OP_END, 8'h5A);

    // Pattern "A?c**" with a zero byte in the middle that must be dropped.
    send_word(OP_APPEND, "A");
    send_word(OP_APPEND, ZERO_BYTE);
    send_word(OP_APPEND, ANY_BYTE);
    send_word(OP_APPEND, "c");
    send_word(OP_APPEND, STAR_BYTE);
    send_word(OP_APPEND, STAR_BYTE);
    send_word(OP_STRING, "a");
    send_word(OP_STRING, "X");
    send_word(OP_STRING, "C");
    send_word(OP_END, 8'h3C);
    send_word(OP_STRING, "A");
    send_word(OP_STRING, 8'hFF);
    send_word(OP_STRING, "c");
    send_word(OP_STRING, STAR_BYTE);
    send_word(OP_END, 8'hC3);

    // Appending in the middle of a string restarts it; '[' is not a letter.
    send_word(OP_STRING, "a");
    send_word(OP_APPEND, "[");
    send_word(OP_STRING, "a");
    send_word(OP_STRING, "b");
    send_word(OP_STRING, "C");
    send_word(OP_STRING, "{");
    send_word(OP_END, 8'h81);
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_END, 8'h7E);

    while (words_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) begin
          send_word(OP_CLEAR, 8'($urandom));
        end
        // A few patterns run past the store to set the overflow flag.
        plen = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
        repeat (plen) send_word(OP_APPEND, pattern_char());
      end

      repeat ($urandom_range(1, 4)) begin
        text.delete();
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
        end else begin
          foreach (cur_pat[i]) begin
            p = cur_pat[i];
            if (p == STAR_BYTE) begin
              repeat ($urandom_range(0, 3)) begin
                text.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255))
                                                           : pick_letter());
              end
            end else if (p == ANY_BYTE) begin
              text.push_back(8'($urandom_range(1, 255)));
            end else begin
              if ((p | 8'h20) >= "a" && (p | 8'h20) <= "z" && $urandom_range(0, 1) == 1) begin
                p = p ^ 8'h20;
              end
              text.push_back(p);
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 2);
            if (pick == 0 && text.size() > 0) begin
              text.delete($urandom_range(0, text.size() - 1));
            end else if (pick == 1 && text.size() > 0) begin
              text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
            end else begin
              text.push_back(pick_letter());
            end
          end
        end
        foreach (text[i]) begin
          if ($urandom_range(0, 19) == 0) begin
            send_word(OP_STRING, ZERO_BYTE);
          end
          send_word(OP_STRING, text[i]);
        end
        send_word(OP_END, 8'($urandom));
      end

      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS wildcard_match_nocase");
    end else begin
      $display("FAIL wildcard_match_nocase");
    end
    $finish;
  end

endmodule
